// ----- rtl/assert_macros.svh -----
// assertion helpers included by the blur core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define BBL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define BBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define BBL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/bbl_pkg.sv -----
package bbl_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 4096;

	localparam int ColW  = $clog2(MaxWidth);
	localparam int RowW  = $clog2(MaxHeight);
	localparam int EffWW = $clog2(MaxWidth + 1);
	localparam int EffHW = $clog2(MaxHeight + 1);

	localparam int WidthRegW  = 11;
	localparam int HeightRegW = 13;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 13;

	localparam logic [WidthRegW-1:0]  WidthReset  = 11'd640;
	localparam logic [HeightRegW-1:0] HeightReset = 13'd480;

	localparam int ChanW      = 8;
	localparam int PixW       = 3 * ChanW;
	localparam int Taps       = 9;
	localparam int SumW       = 12;
	localparam int XW         = SumW + 1;
	localparam int CntW       = 4;
	localparam int RecipW     = 17;
	localparam int RecipShift = 17;
	localparam int ProdW      = XW + RecipW;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1
	} cfg_idx_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef logic [ChanW-1:0] chan_t;
	typedef logic [PixW-1:0] pix_t;
	typedef pix_t [Taps-1:0] win_t;
	typedef logic [Taps-1:0] tap_mask_t;

	// ceil(2^17 / (2n)); exact for (2*sum + n) up to 2*9*255 + 9
	function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] n);
		logic [RecipW-1:0] m;
		case (n)
			4'd1:    m = 17'd65536;
			4'd2:    m = 17'd32768;
			4'd3:    m = 17'd21846;
			4'd4:    m = 17'd16384;
			4'd5:    m = 17'd13108;
			4'd6:    m = 17'd10923;
			4'd7:    m = 17'd9363;
			4'd8:    m = 17'd8192;
			4'd9:    m = 17'd7282;
			default: m = 17'd65536;
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/bbl_cfg_if.sv -----
interface bbl_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [bbl_pkg::CfgIdxW-1:0]  index;
	logic [bbl_pkg::CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/bbl_in_if.sv -----
interface bbl_in_if;
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [bbl_pkg::ChanW-1:0] red_in;
	logic [bbl_pkg::ChanW-1:0] green_in;
	logic [bbl_pkg::ChanW-1:0] blue_in;

	modport source (output valid, operation, red_in, green_in, blue_in, input ready);
	modport sink (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

// ----- rtl/bbl_out_if.sv -----
interface bbl_out_if;
	logic                      valid;
	logic                      ready;
	logic [bbl_pkg::ChanW-1:0] red_out;
	logic [bbl_pkg::ChanW-1:0] green_out;
	logic [bbl_pkg::ChanW-1:0] blue_out;
	logic                      run_last;
	logic                      frame_last;

	modport source (output valid, red_out, green_out, blue_out, run_last, frame_last,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, run_last, frame_last,
		output ready);
endinterface

// ----- rtl/box_blur_3x3_core.sv -----
// one item at a time: a pixel item writes and reads the row stores, then each result goes
// through the mean unit and waits for a free output register; a row end gives a second
// result and a drain tick first reads three columns; new items wait for idle, so the pace
// is set by row store reads, the two-stage mean unit (column sums, reciprocal multiply)
// reset clears counters, drain state and valid flags, sets the frame to 640x480;
// the row stores are not cleared and need no clearing pass
`include "assert_macros.svh"

module box_blur_3x3_core (
	input logic        clk,
	input logic        arst_n,
	bbl_cfg_if.sink    cfg,
	bbl_in_if.sink     pix_in,
	bbl_out_if.source  pix_out
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PRD  = 6'b000010,
		S_DRD  = 6'b000100,
		S_CALC = 6'b001000,
		S_WAIT = 6'b010000,
		S_PUSH = 6'b100000
	} state_t;

	state_t                            state_q;
	logic [bbl_pkg::WidthRegW-1:0]     width_q;
	logic [bbl_pkg::HeightRegW-1:0]    height_q;
	logic [bbl_pkg::ColW-1:0]          col_q;
	logic [bbl_pkg::RowW-1:0]          row_q;
	logic                              drain_q;
	logic [bbl_pkg::ColW-1:0]          didx_q;
	logic [bbl_pkg::ColW-1:0]          addr_q;
	logic [1:0]                        cnt_q;
	logic                              pend_a_q;
	logic                              pend_b_q;
	logic                              flast_q;
	bbl_pkg::pix_t                     px_q;
	bbl_pkg::win_t                     win_q;
	bbl_pkg::tap_mask_t                mask_a_q;
	bbl_pkg::tap_mask_t                mask_b_q;
	logic                              out_valid_q;
	bbl_pkg::pix_t                     out_rgb_q;
	logic                              out_run_last_q;
	logic                              out_frame_last_q;

	logic [bbl_pkg::EffWW-1:0]         eff_w;
	logic [bbl_pkg::EffHW-1:0]         eff_h;
	logic                              row_end;
	logic                              row_last;
	logic                              pix_ok;
	logic                              tick_ok;
	logic                              d_last;
	logic                              h_ge2;
	logic                              r_ge1;
	logic                              r_ge2;
	logic                              c_ge1;
	logic                              c_ge2;
	logic                              accept;
	logic                              acc_pix;
	logic                              acc_tick;
	logic                              cfg_wr;
	logic                              slot_free;
	logic                              push_now;
	bbl_pkg::tap_mask_t                mask_a_new;
	bbl_pkg::tap_mask_t                mask_b_new;
	bbl_pkg::tap_mask_t                mask_d_new;
	logic [bbl_pkg::ColW-1:0]          raddr;
	logic                              we;
	bbl_pkg::pix_t                     older_rd;
	bbl_pkg::pix_t                     newer_rd;
	logic                              mean_done;
	bbl_pkg::pix_t                     mean_rgb;

	function automatic bbl_pkg::tap_mask_t build_mask(input logic [2:0] cols,
		input logic [2:0] rows);
		bbl_pkg::tap_mask_t m;
		for (int col = 0; col < 3; col++) begin
			for (int row = 0; row < 3; row++) begin
				m[col * 3 + row] = cols[col] & rows[row];
			end
		end
		return m;
	endfunction

	// out-of-range sizes act as 1 or the maximum
	always_comb begin
		if (width_q == '0) begin
			eff_w = bbl_pkg::EffWW'(1);
		end else if (32'(width_q) > 32'(bbl_pkg::MaxWidth)) begin
			eff_w = bbl_pkg::EffWW'(bbl_pkg::MaxWidth);
		end else begin
			eff_w = bbl_pkg::EffWW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = bbl_pkg::EffHW'(1);
		end else if (32'(height_q) > 32'(bbl_pkg::MaxHeight)) begin
			eff_h = bbl_pkg::EffHW'(bbl_pkg::MaxHeight);
		end else begin
			eff_h = bbl_pkg::EffHW'(height_q);
		end
	end

	assign row_end  = (bbl_pkg::EffWW'(col_q) + bbl_pkg::EffWW'(1)) == eff_w;
	assign row_last = (bbl_pkg::EffHW'(row_q) + bbl_pkg::EffHW'(1)) >= eff_h;
	assign pix_ok   = !drain_q && (bbl_pkg::EffWW'(col_q) < eff_w)
		&& (bbl_pkg::EffHW'(row_q) < eff_h);
	assign tick_ok  = drain_q && (bbl_pkg::EffWW'(didx_q) < eff_w);
	assign d_last   = (bbl_pkg::EffWW'(didx_q) + bbl_pkg::EffWW'(1)) >= eff_w;
	assign h_ge2    = eff_h != bbl_pkg::EffHW'(1);
	assign r_ge1    = row_q != '0;
	assign r_ge2    = row_q > bbl_pkg::RowW'(1);
	assign c_ge1    = col_q != '0;
	assign c_ge2    = col_q > bbl_pkg::ColW'(1);

	// window rows: 0 two above, 1 one above, 2 current; drain puts older in 1, newer in 2
	assign mask_a_new = build_mask({1'b1, 1'b1, c_ge2}, {1'b1, 1'b1, r_ge2});
	assign mask_b_new = build_mask({1'b1, c_ge1, 1'b0}, {1'b1, 1'b1, r_ge2});
	assign mask_d_new = build_mask({!d_last, 1'b1, didx_q != '0}, {1'b1, h_ge2, 1'b0});

	assign pix_in.ready = state_q == S_IDLE;
	assign accept   = pix_in.valid && pix_in.ready;
	assign acc_pix  = accept && (pix_in.operation == bbl_pkg::OP_PIXEL) && pix_ok;
	assign acc_tick = accept && (pix_in.operation == bbl_pkg::OP_DRAIN) && tick_ok;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	assign slot_free = !out_valid_q || pix_out.ready;
	assign push_now  = (state_q == S_PUSH) && slot_free;

	// drain reads columns i-1, i, i+1 in turn
	assign raddr = (state_q == S_DRD)
		? addr_q + bbl_pkg::ColW'(cnt_q) - bbl_pkg::ColW'(1) : col_q;
	assign we = state_q == S_PRD;

	bbl_ram #(
		.Width(bbl_pkg::PixW),
		.Depth(bbl_pkg::MaxWidth)
	) u_older (
		.clk  (clk),
		.we   (we),
		.waddr(addr_q),
		.wdata(newer_rd),
		.raddr(raddr),
		.rdata(older_rd)
	);

	bbl_ram #(
		.Width(bbl_pkg::PixW),
		.Depth(bbl_pkg::MaxWidth)
	) u_newer (
		.clk  (clk),
		.we   (we),
		.waddr(addr_q),
		.wdata(px_q),
		.raddr(raddr),
		.rdata(newer_rd)
	);

	bbl_mean u_mean (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == S_CALC),
		.win   (win_q),
		.mask  (pend_a_q ? mask_a_q : mask_b_q),
		.done  (mean_done),
		.mean  (mean_rgb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= bbl_pkg::WidthReset;
			height_q    <= bbl_pkg::HeightReset;
			col_q       <= '0;
			row_q       <= '0;
			drain_q     <= 1'b0;
			didx_q      <= '0;
			cnt_q       <= '0;
			pend_a_q    <= 1'b0;
			pend_b_q    <= 1'b0;
			flast_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_now) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (acc_pix) begin
						pend_a_q <= r_ge1 && c_ge1;
						pend_b_q <= r_ge1 && row_end;
						flast_q  <= 1'b0;
						state_q  <= S_PRD;
						if (row_end) begin
							col_q <= '0;
							if (row_last) begin
								row_q   <= '0;
								drain_q <= 1'b1;
								didx_q  <= '0;
							end else begin
								row_q <= row_q + bbl_pkg::RowW'(1);
							end
						end else begin
							col_q <= col_q + bbl_pkg::ColW'(1);
						end
					end else if (acc_tick) begin
						pend_a_q <= 1'b1;
						pend_b_q <= 1'b0;
						flast_q  <= d_last;
						cnt_q    <= '0;
						state_q  <= S_DRD;
						if (d_last) begin
							drain_q <= 1'b0;
							didx_q  <= '0;
						end else begin
							didx_q <= didx_q + bbl_pkg::ColW'(1);
						end
					end
				end
				S_PRD: begin
					state_q <= (pend_a_q || pend_b_q) ? S_CALC : S_IDLE;
				end
				S_DRD: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (mean_done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (slot_free) begin
						if (pend_a_q) begin
							pend_a_q <= 1'b0;
							state_q  <= pend_b_q ? S_CALC : S_IDLE;
						end else begin
							pend_b_q <= 1'b0;
							state_q  <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// a write to the width or height register restarts the frame
			if (cfg_wr) begin
				case (cfg.index)
					bbl_pkg::CFG_WIDTH: begin
						width_q <= cfg.data[bbl_pkg::WidthRegW-1:0];
						col_q   <= '0;
						row_q   <= '0;
						drain_q <= 1'b0;
						didx_q  <= '0;
					end
					bbl_pkg::CFG_HEIGHT: begin
						height_q <= cfg.data[bbl_pkg::HeightRegW-1:0];
						col_q    <= '0;
						row_q    <= '0;
						drain_q  <= 1'b0;
						didx_q   <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_pix) begin
			px_q     <= {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
			addr_q   <= col_q;
			mask_a_q <= mask_a_new;
			mask_b_q <= mask_b_new;
		end else if (acc_tick) begin
			addr_q   <= didx_q;
			mask_a_q <= mask_d_new;
		end

		if (state_q == S_PRD) begin
			for (int k = 0; k < 6; k++) begin
				win_q[k] <= win_q[k + 3];
			end
			win_q[6] <= older_rd;
			win_q[7] <= newer_rd;
			win_q[8] <= px_q;
		end

		if (state_q == S_DRD) begin
			case (cnt_q)
				2'd1: begin
					win_q[1] <= older_rd;
					win_q[2] <= newer_rd;
				end
				2'd2: begin
					win_q[4] <= older_rd;
					win_q[5] <= newer_rd;
				end
				2'd3: begin
					win_q[7] <= older_rd;
					win_q[8] <= newer_rd;
				end
				default: begin
				end
			endcase
		end

		if (push_now) begin
			out_rgb_q        <= mean_rgb;
			out_run_last_q   <= pend_a_q ? !pend_b_q : 1'b1;
			out_frame_last_q <= flast_q;
		end
	end

	assign pix_out.valid      = out_valid_q;
	assign pix_out.red_out    = out_rgb_q[bbl_pkg::PixW-1 -: bbl_pkg::ChanW];
	assign pix_out.green_out  = out_rgb_q[bbl_pkg::PixW-1-bbl_pkg::ChanW -: bbl_pkg::ChanW];
	assign pix_out.blue_out   = out_rgb_q[bbl_pkg::ChanW-1:0];
	assign pix_out.run_last   = out_run_last_q;
	assign pix_out.frame_last = out_frame_last_q;

	`BBL_ASSERT_IMPL(a_done_in_wait, clk, arst_n, mean_done, state_q == S_WAIT)
	`BBL_ASSERT_NEXT(a_tick_reads, clk, arst_n, acc_tick, state_q == S_DRD)
	`BBL_ASSERT_IMPL(a_drain_single, clk, arst_n, state_q == S_DRD, !pend_b_q)
	`BBL_ASSERT_IMPL(a_flast_is_last, clk, arst_n, pix_out.valid && pix_out.frame_last,
		pix_out.run_last)

endmodule

// ----- rtl/bbl_ram.sv -----
module bbl_ram #(
	parameter int Width = 24,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/bbl_mean.sv -----
module bbl_mean (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bbl_pkg::win_t      win,
	input  bbl_pkg::tap_mask_t mask,
	output logic               done,
	output bbl_pkg::pix_t      mean
);

	logic [bbl_pkg::SumW-1:0]  part [3][3];
	logic [bbl_pkg::SumW-1:0]  sum_d [3];
	logic [bbl_pkg::SumW-1:0]  sum_s1 [3];
	logic [bbl_pkg::CntW-1:0]  cnt_s1;
	logic                      vld_s1;
	logic [bbl_pkg::XW-1:0]    x_d [3];
	logic [bbl_pkg::ProdW-1:0] prod_s2 [3];
	logic                      vld_s2;

	// column partial sums first, then the three columns
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int col = 0; col < 3; col++) begin
				part[ch][col] = '0;
				for (int row = 0; row < 3; row++) begin
					if (mask[col * 3 + row]) begin
						part[ch][col] = part[ch][col] + bbl_pkg::SumW'(
							win[col * 3 + row][bbl_pkg::PixW - 1 - ch * bbl_pkg::ChanW -: bbl_pkg::ChanW]);
					end
				end
			end
			sum_d[ch] = part[ch][0] + part[ch][1] + part[ch][2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_s1 <= sum_d;
			cnt_s1 <= bbl_pkg::CntW'($countones(mask));
		end
	end

	// round half up: (2*sum + n) / (2n) by reciprocal multiply
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			x_d[ch] = bbl_pkg::XW'({sum_s1[ch], 1'b0}) + bbl_pkg::XW'(cnt_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			for (int ch = 0; ch < 3; ch++) begin
				prod_s2[ch] <= bbl_pkg::ProdW'(x_d[ch]) *
					bbl_pkg::ProdW'(bbl_pkg::recip(cnt_s1));
			end
		end
	end

	assign done = vld_s2;
	assign mean = {prod_s2[0][bbl_pkg::RecipShift + bbl_pkg::ChanW - 1 -: bbl_pkg::ChanW],
		prod_s2[1][bbl_pkg::RecipShift + bbl_pkg::ChanW - 1 -: bbl_pkg::ChanW],
		prod_s2[2][bbl_pkg::RecipShift + bbl_pkg::ChanW - 1 -: bbl_pkg::ChanW]};

endmodule

// ----- test/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bbl_pkg::*;

	localparam int StallLimit = 5000;
	localparam int SettleCycles = 20;
	localparam int ReportLimit = 10;
	localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

	// 3x3 test frame: all-zero, all-ones and mixed channels
	localparam pix_t GridPix [9] = '{
		24'h000000, 24'hFFFFFF, 24'h010203,
		24'hFF00FF, 24'h00FF00, 24'h808080,
		24'hFFFFFF, 24'h000001, 24'h7F7F80
	};

	typedef struct {
		op_t   op;
		chan_t red;
		chan_t green;
		chan_t blue;
	} pixel_item_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  run_last;
		logic  frame_last;
	} blur_result_t;

	logic clk;
	logic arst_n;

	bbl_cfg_if cfg_bus ();
	bbl_in_if  in_bus ();
	bbl_out_if out_bus ();

	box_blur_3x3_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.pix_in  (in_bus),
		.pix_out (out_bus)
	);

	pixel_item_t  pixel_queue [$];
	blur_result_t blur_expected [$];

	int unsigned sender_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned items_done = 0;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	bit          frame_open = 1'b0;

	// blur state as the block should hold it
	logic [WidthRegW-1:0]  width_reg = WidthReset;
	logic [HeightRegW-1:0] height_reg = HeightReset;
	pix_t        row_old [MaxWidth] = '{default: '0};
	pix_t        row_new [MaxWidth] = '{default: '0};
	pix_t        win [Taps] = '{default: '0};
	int unsigned row_idx = 0;
	int unsigned col_idx = 0;
	int unsigned drain_col = 0;
	bit          drain_on = 1'b0;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		in_bus.valid = 1'b0;
		in_bus.operation = OP_PIXEL;
		in_bus.red_in = '0;
		in_bus.green_in = '0;
		in_bus.blue_in = '0;
		out_bus.ready = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MaxWidth) return MaxWidth;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0) return 1;
		if (height_reg > MaxHeight) return MaxHeight;
		return height_reg;
	endfunction

	function automatic blur_result_t rounded_mean(int unsigned sr, int unsigned sg,
		int unsigned sb, int unsigned n, bit run_last, bit frame_last);
		blur_result_t res;
		int unsigned d;
		d = (n == 0) ? 1 : n;
		res.red = chan_t'((2 * sr + d) / (2 * d));
		res.green = chan_t'((2 * sg + d) / (2 * d));
		res.blue = chan_t'((2 * sb + d) / (2 * d));
		res.run_last = run_last;
		res.frame_last = frame_last;
		return res;
	endfunction

	// mean over window columns first..2, top row only when use_top
	function automatic blur_result_t window_mean(int first, bit skip_first, bit use_top,
		bit run_last);
		int unsigned sr, sg, sb, n;
		sr = 0;
		sg = 0;
		sb = 0;
		n = 0;
		for (int col = first; col < 3; col++) begin
			if (!(col == first && skip_first)) begin
				for (int row = use_top ? 0 : 1; row < 3; row++) begin
					sr += win[col * 3 + row][23:16];
					sg += win[col * 3 + row][15:8];
					sb += win[col * 3 + row][7:0];
					n++;
				end
			end
		end
		return rounded_mean(sr, sg, sb, n, run_last, 1'b0);
	endfunction

	task automatic blur_predict(op_t op, chan_t r, chan_t g, chan_t b);
		int unsigned w, h, lo, hi, sr, sg, sb, n;
		pix_t above2, above1;
		bit row_end, last;
		w = eff_width();
		h = eff_height();
		if (op == OP_DRAIN) begin
			if (!drain_on || drain_col >= w) return;
			lo = (drain_col == 0) ? 0 : drain_col - 1;
			hi = (drain_col + 1 < w) ? drain_col + 1 : drain_col;
			sr = 0;
			sg = 0;
			sb = 0;
			n = 0;
			for (int unsigned j = lo; j <= hi; j++) begin
				sr += row_new[j][23:16];
				sg += row_new[j][15:8];
				sb += row_new[j][7:0];
				n++;
				if (h >= 2) begin
					sr += row_old[j][23:16];
					sg += row_old[j][15:8];
					sb += row_old[j][7:0];
					n++;
				end
			end
			last = (drain_col + 1 >= w);
			blur_expected.push_back(rounded_mean(sr, sg, sb, n, 1'b1, last));
			if (last) begin
				drain_on = 1'b0;
				drain_col = 0;
			end else begin
				drain_col++;
			end
		end else begin
			if (drain_on || col_idx >= w || row_idx >= h) return;
			above2 = row_old[col_idx];
			above1 = row_new[col_idx];
			for (int k = 0; k < 6; k++)
				win[k] = win[k + 3];
			win[6] = above2;
			win[7] = above1;
			win[8] = {r, g, b};
			row_old[col_idx] = above1;
			row_new[col_idx] = {r, g, b};
			row_end = (col_idx + 1 == w);
			if (row_idx >= 1) begin
				if (col_idx >= 1)
					blur_expected.push_back(window_mean(0, col_idx < 2, row_idx >= 2, !row_end));
				if (row_end)
					blur_expected.push_back(window_mean(1, col_idx < 1, row_idx >= 2, 1'b1));
			end
			if (row_end) begin
				col_idx = 0;
				if (row_idx + 1 >= h) begin
					row_idx = 0;
					drain_on = 1'b1;
					drain_col = 0;
				end else begin
					row_idx++;
				end
			end else begin
				col_idx++;
			end
		end
	endtask

	// pixel source
	always @(posedge clk) begin : feed
		pixel_item_t nxt;
		if (!arst_n) begin
			in_bus.valid <= 1'b0;
		end else begin
			if (in_bus.valid && in_bus.ready)
				blur_predict(op_t'(in_bus.operation), in_bus.red_in, in_bus.green_in,
					in_bus.blue_in);
			if (!in_bus.valid || in_bus.ready) begin
				if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					nxt = pixel_queue.pop_front();
					in_bus.valid <= 1'b1;
					in_bus.operation <= nxt.op;
					in_bus.red_in <= nxt.red;
					in_bus.green_in <= nxt.green;
					in_bus.blue_in <= nxt.blue;
				end else begin
					in_bus.valid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_result(string what, blur_result_t want, blur_result_t got);
		error_count++;
		if (error_count <= ReportLimit) begin
			$display("%0t %0s: expected rgb %0d/%0d/%0d run_last %0b frame_last %0b",
				$realtime, what, want.red, want.green, want.blue, want.run_last,
				want.frame_last);
			$display("    got rgb %0d/%0d/%0d run_last %0b frame_last %0b",
				got.red, got.green, got.blue, got.run_last, got.frame_last);
		end
	endtask

	// result sink and checker
	always @(posedge clk) begin : check
		blur_result_t got, want;
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
		end else begin
			if (out_bus.valid && out_bus.ready) begin
				got.red = out_bus.red_out;
				got.green = out_bus.green_out;
				got.blue = out_bus.blue_out;
				got.run_last = out_bus.run_last;
				got.frame_last = out_bus.frame_last;
				if (blur_expected.size() == 0) begin
					flag_result("unexpected pixel", '0, got);
				end else begin
					want = blur_expected.pop_front();
					if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue || got.run_last !== want.run_last
						|| got.frame_last !== want.frame_last)
						flag_result("pixel mismatch", want, got);
				end
			end
			out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("timeout: no handshake for %0d cycles", StallLimit);
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	function automatic chan_t rand_chan();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return chan_t'($urandom_range(255));
		endcase
	endfunction

	function automatic pix_t rand_pixel();
		return {rand_chan(), rand_chan(), rand_chan()};
	endfunction

	task automatic push_item(op_t op, pix_t px);
		pixel_queue.push_back('{op, px[23:16], px[15:8], px[7:0]});
		items_done++;
	endtask

	// hold off until every item is in and every result is out, then let the block settle
	task automatic wait_drained();
		do @(negedge clk);
		while (pixel_queue.size() != 0 || in_bus.valid || blur_expected.size() != 0);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		wait_drained();
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		do @(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		if (idx == CFG_WIDTH || idx == CFG_HEIGHT) begin
			if (idx == CFG_WIDTH)
				width_reg = val[WidthRegW-1:0];
			else
				height_reg = val[HeightRegW-1:0];
			row_idx = 0;
			col_idx = 0;
			drain_on = 1'b0;
			drain_col = 0;
		end
		@(negedge clk);
	endtask

	// one frame of w x h pixels and its drain; noisy frames get ignored items and cut-offs
	task automatic push_frame(int unsigned w, int unsigned h, bit noisy);
		int unsigned total, cut_at, drain_len;
		total = w * h;
		cut_at = total;
		if (noisy && $urandom_range(99) < 8)
			cut_at = $urandom_range(total - 1);
		for (int unsigned k = 0; k < cut_at; k++) begin
			if (noisy && $urandom_range(99) < 3)
				push_item(OP_DRAIN, rand_pixel());
			push_item(OP_PIXEL, rand_pixel());
		end
		if (cut_at < total) begin
			frame_open = 1'b1;
			return;
		end
		drain_len = w;
		if (noisy && $urandom_range(99) < 5)
			drain_len = $urandom_range(w - 1);
		for (int unsigned k = 0; k < drain_len; k++) begin
			if (noisy && $urandom_range(99) < 5)
				push_item(OP_PIXEL, rand_pixel());
			push_item(OP_DRAIN, rand_pixel());
		end
		frame_open = (drain_len < w);
		if (!frame_open && noisy && $urandom_range(99) < 10)
			push_item(OP_DRAIN, rand_pixel());
	endtask

	task automatic random_frame();
		int unsigned pick, wv, hv;
		logic [CfgDataW-1:0] wdata;
		if (frame_open || $urandom_range(99) < 80) begin
			pick = $urandom_range(99);
			wv = (pick < 80) ? $urandom_range(6, 1) : (pick < 95) ? $urandom_range(24, 7) : 0;
			pick = $urandom_range(99);
			hv = (pick < 80) ? $urandom_range(5, 1) : (pick < 95) ? $urandom_range(12, 6) : 0;
			wdata = CfgDataW'(wv);
			// bits above the width register are dropped
			if ($urandom_range(9) == 0)
				wdata[CfgDataW-1:WidthRegW] = 2'($urandom_range(3, 1));
			write_reg(CFG_WIDTH, wdata);
			write_reg(CFG_HEIGHT, CfgDataW'(hv));
		end
		push_frame(eff_width(), eff_height(), 1'b1);
	endtask

	initial begin
		sender_idle_pct = 20;
		sink_stall_pct = 57;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain tick with nothing to drain
		push_item(OP_DRAIN, 24'h123456);

		// 3x3 frame: corners, edges, center, then an ignored pixel and an extra tick
		write_reg(CFG_WIDTH, 13'd3);
		write_reg(CFG_HEIGHT, 13'd3);
		foreach (GridPix[i])
			push_item(OP_PIXEL, GridPix[i]);
		push_item(OP_PIXEL, 24'hA5A5A5);
		repeat (3) push_item(OP_DRAIN, 24'h000000);
		push_item(OP_DRAIN, 24'hFFFFFF);

		// zero size acts as one: single pixel frame
		write_reg(CFG_WIDTH, 13'd0);
		write_reg(CFG_HEIGHT, 13'd0);
		push_item(OP_PIXEL, 24'hFE01FF);
		push_item(OP_DRAIN, 24'h000000);

		// unused register indexes must not restart the frame
		write_reg(CFG_WIDTH, 13'd2);
		write_reg(CFG_HEIGHT, 13'd2);
		push_item(OP_PIXEL, 24'hFFFFFF);
		push_item(OP_PIXEL, 24'h000000);
		write_reg(CFG_SPARE_A, 13'h1FFF);
		write_reg(CFG_SPARE_B, 13'h0001);
		push_item(OP_PIXEL, 24'h0000FF);
		push_item(OP_PIXEL, 24'hFF0000);
		repeat (2) push_item(OP_DRAIN, 24'h00FF00);

		while (items_done < 180)
			random_frame();

		wait_drained();
		sender_idle_pct = 57;
		sink_stall_pct = 20;
		while (items_done < 360)
			random_frame();

		wait_drained();
		sender_idle_pct = 0;
		sink_stall_pct = 0;

		// oversized width clamps to the row store size: the row ends at the last entry
		write_reg(CFG_WIDTH, 13'h07FF);
		write_reg(CFG_HEIGHT, 13'd1);
		repeat (MaxWidth) push_item(OP_PIXEL, rand_pixel());
		repeat (2) push_item(OP_DRAIN, rand_pixel());
		frame_open = 1'b1;

		// oversized height, frame abandoned early
		write_reg(CFG_WIDTH, 13'd1);
		write_reg(CFG_HEIGHT, 13'h1FFF);
		repeat (16) push_item(OP_PIXEL, rand_pixel());
		frame_open = 1'b1;

		// exact maxima, frame abandoned early
		write_reg(CFG_WIDTH, CfgDataW'(MaxWidth));
		write_reg(CFG_HEIGHT, CfgDataW'(MaxHeight));
		repeat (16) push_item(OP_PIXEL, rand_pixel());
		frame_open = 1'b1;

		while (items_done < 1400)
			random_frame();

		wait_drained();
		if (error_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
